// ----- hdl/aes_pkg.sv -----
`default_nettype none
package aes_pkg;

  typedef logic [127:0] block_t;
  typedef logic [7:0] byte_t;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ENCRYPT = 2'd1;
  localparam logic [1:0] OP_DECRYPT = 2'd2;

  localparam logic [3:0] MIN_ROUNDS = 4'd10;

  typedef struct packed {
    logic       start;
    logic       decrypt;
    logic       first;
    logic       last;
    logic       capture;
  } aes_cmd_t;

  function automatic byte_t xtime(byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gf_mul(byte_t a, byte_t b);
    byte_t p;
    byte_t x;
    p = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gf_mul = p;
  endfunction

  function automatic byte_t gf_inv(byte_t x);
    byte_t r;
    byte_t b;
    r = 8'd1;
    b = x;
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gf_mul(r, b);
      b = gf_mul(b, b);
    end
    gf_inv = r;
  endfunction

  function automatic byte_t rotl8(byte_t x, int n);
    rotl8 = byte_t'((x << n) | (x >> (8 - n)));
  endfunction

  function automatic byte_t sbox(byte_t x);
    byte_t b;
    b = gf_inv(x);
    sbox = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic byte_t inv_sbox(byte_t s);
    inv_sbox = gf_inv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
  endfunction

  function automatic byte_t get_byte(block_t s, int i);
    get_byte = s[127 - 8 * i -: 8];
  endfunction

  function automatic block_t sub_shift(block_t s, logic inverse);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inverse)
          t[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8] = inv_sbox(get_byte(s, r + 4 * c));
        else
          t[127 - 8 * (r + 4 * c) -: 8] = sbox(get_byte(s, r + 4 * ((c + r) & 3)));
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix(block_t s, logic inverse);
    block_t t;
    byte_t m [4];
    byte_t v;
    t = '0;
    if (inverse) begin
      m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
    end else begin
      m[0] = 8'd2; m[1] = 8'd3; m[2] = 8'd1; m[3] = 8'd1;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        v = '0;
        for (int k = 0; k < 4; k++) v = v ^ gf_mul(m[(k - r + 4) & 3], get_byte(s, 4 * c + k));
        t[127 - 8 * (4 * c + r) -: 8] = v;
      end
    end
    mix = t;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/aes_if.sv -----
`default_nettype none
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  key_slot;
  logic [63:0] data_high;
  logic [63:0] data_low;
  modport source (output valid, operation, key_slot, data_high, data_low, input ready);
  modport sink (input valid, operation, key_slot, data_high, data_low, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, block_high, block_low, input ready);
  modport sink (input valid, block_high, block_low, output ready);
endinterface

interface aes_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/aes_datapath.sv -----
`default_nettype none
module aes_datapath #(
  parameter int SLOTS = 15,
  parameter int SW = 4
) (
  input  wire logic             clk,
  input  wire aes_pkg::aes_cmd_t cmd,
  input  wire logic             key_we,
  input  wire logic [SW-1:0]    key_waddr,
  input  wire aes_pkg::block_t  key_wdata,
  input  wire logic [SW-1:0]    key_raddr,
  input  wire aes_pkg::block_t  block_in,
  output aes_pkg::block_t       result
);
  aes_pkg::block_t keys [SLOTS];
  aes_pkg::block_t key_q;
  aes_pkg::block_t state;
  aes_pkg::block_t sub;
  aes_pkg::block_t next;

  always_ff @(posedge clk) begin
    if (key_we) keys[key_waddr] <= key_wdata;
    key_q <= keys[key_raddr];
  end

  // Decryption applies InvMixColumns after the key addition.
  always_comb begin
    sub = aes_pkg::sub_shift(state, cmd.decrypt);
    if (cmd.first) next = state ^ key_q;
    else if (cmd.last) next = sub ^ key_q;
    else if (cmd.decrypt) next = aes_pkg::mix(sub ^ key_q, 1'b1);
    else next = aes_pkg::mix(sub, 1'b0) ^ key_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.start) state <= block_in;
    else if (cmd.capture) state <= next;
  end

  assign result = state;
endmodule
`default_nettype wire

// ----- hdl/aes_ctrl.sv -----
`default_nettype none
module aes_ctrl #(
  parameter int MAX_ROUNDS = 14,
  parameter int SW = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_fire,
  input  wire logic [1:0]     operation,
  input  wire logic [3:0]     rounds,
  input  wire logic           out_ready,
  output logic                busy,
  output logic                out_valid,
  output aes_pkg::aes_cmd_t   cmd,
  output logic [SW-1:0]       key_raddr
);
  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_RUN, S_DONE} state_t;
  state_t      st;
  logic        dec;
  logic [SW-1:0] cnt;
  logic [SW-1:0] nr;
  logic [SW-1:0] ahead;
  logic [SW-1:0] raddr_next;

  assign busy = (st != S_IDLE);
  assign out_valid = (st == S_DONE);
  assign nr = SW'(rounds < aes_pkg::MIN_ROUNDS ? aes_pkg::MIN_ROUNDS :
              (32'(rounds) > MAX_ROUNDS ? 4'(MAX_ROUNDS) : rounds));

  // The key read address runs one round ahead of the round being computed,
  // since the store output is registered.
  always_comb begin
    cmd = '0;
    cmd.decrypt = dec;
    cmd.start = in_fire && (operation == aes_pkg::OP_ENCRYPT || operation == aes_pkg::OP_DECRYPT);
    cmd.capture = (st == S_RUN);
    cmd.first = (cnt == '0);
    cmd.last = (cnt == nr);
    ahead = (st == S_FETCH) ? cnt + SW'(1) : cnt + SW'(2);
    raddr_next = dec ? nr - ahead : ahead;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      cnt <= '0;
      dec <= 1'b0;
      key_raddr <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (cmd.start) begin
            dec <= (operation == aes_pkg::OP_DECRYPT);
            cnt <= '0;
            key_raddr <= (operation == aes_pkg::OP_DECRYPT) ? nr : '0;
            st <= S_FETCH;
          end
        end
        S_FETCH: begin
          key_raddr <= raddr_next;
          st <= S_RUN;
        end
        S_RUN: begin
          if (ahead <= nr) key_raddr <= raddr_next;
          if (cmd.last) st <= S_DONE;
          else cnt <= cnt + 1'b1;
        end
        S_DONE: if (out_ready) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/aes_block_cipher_top.sv -----
// After acceptance the controller fetches the first key (S_FETCH), then runs
// rounds 0 to nr (S_RUN), nr the clamped round count, and holds the result
// in S_DONE until taken; no new block is accepted before then. One round
// per cycle through a single round unit reading one key per cycle.
// Key loads write the key store when accepted. Reset sets the round count to
// 10 and idles the controller; the key store is not cleared.
`default_nettype none
module aes_block_cipher_top #(
  parameter int MAX_ROUNDS = 14
) (
  input wire logic clk,
  input wire logic rst,
  aes_in_if.sink   in_ch,
  aes_out_if.source out_ch,
  aes_cfg_if.sink  cfg
);
  localparam int SLOTS = MAX_ROUNDS + 1;
  localparam int SW = $clog2(SLOTS);

  logic [3:0] round_count;
  logic busy;
  logic in_fire;
  logic key_we;
  aes_pkg::aes_cmd_t cmd;
  logic [SW-1:0] key_raddr;
  aes_pkg::block_t result;

  assign cfg.ready = 1'b1;
  assign in_ch.ready = !busy;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign key_we = in_fire && in_ch.operation == aes_pkg::OP_LOAD &&
                  32'(in_ch.key_slot) < SLOTS;

  always_ff @(posedge clk) begin
    if (rst) round_count <= 4'd10;
    else if (cfg.valid) round_count <= cfg.data;
  end

  aes_ctrl #(.MAX_ROUNDS(MAX_ROUNDS), .SW(SW)) u_ctrl (
    .clk, .rst, .in_fire, .operation(in_ch.operation), .rounds(round_count),
    .out_ready(out_ch.ready), .busy, .out_valid(out_ch.valid), .cmd, .key_raddr
  );

  aes_datapath #(.SLOTS(SLOTS), .SW(SW)) u_dp (
    .clk, .cmd, .key_we, .key_waddr(SW'(in_ch.key_slot)),
    .key_wdata({in_ch.data_high, in_ch.data_low}), .key_raddr,
    .block_in({in_ch.data_high, in_ch.data_low}), .result
  );

  assign out_ch.block_high = result[127:64];
  assign out_ch.block_low = result[63:0];

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(result))
    else $error("result changed while stalled");
`endif
endmodule
`default_nettype wire
